[sv/ppf_pkg.sv]
package ppf_pkg;

  // Block size and fade length
  localparam int PIXELS     = 64;
  localparam int FADE_STEPS = 25;

  // Field widths
  localparam int COLOR_W = 8;
  localparam int STEP_W  = 5;
  localparam int IDX_W   = 8;
  localparam int PIX_AW  = (PIXELS > 1) ? $clog2(PIXELS) : 1;

  // One stored entry: red, green, blue, step
  localparam int ENTRY_W = 3 * COLOR_W + STEP_W;

  // Divide by FADE_STEPS as multiply by a rounded-up reciprocal, then shift.
  // Exact while color * remain * error stays below 2**FADE_SHIFT.
  localparam int FADE_SHIFT = 19;
  localparam int FADE_RECIP = (2 ** FADE_SHIFT + FADE_STEPS - 1) / FADE_STEPS;
  localparam int PROD_W     = COLOR_W + STEP_W;
  localparam int RECIP_W    = $clog2(FADE_RECIP + 1);
  localparam int MUL_W      = (PROD_W > RECIP_W) ? PROD_W : RECIP_W;

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [STEP_W-1:0]  step_t;
  typedef logic [PIX_AW-1:0]  pix_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  // Operation codes
  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_MULA,
    S_MULB,
    S_EMIT
  } state_t;

endpackage

[sv/ppf_if.sv]
// Input channel: set or tick beats
interface ppf_in_if;
  import ppf_pkg::*;
  logic             valid;
  logic             ready;
  logic             operation;
  logic [IDX_W-1:0] pixel_index;
  color_t           set_red;
  color_t           set_green;
  color_t           set_blue;

  modport source (output valid, operation, pixel_index, set_red, set_green, set_blue,
                  input ready);
  modport sink   (input valid, operation, pixel_index, set_red, set_green, set_blue,
                  output ready);
endinterface

// Result channel: one beat per pixel on a tick
interface ppf_out_if;
  import ppf_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] out_index;
  color_t           out_red;
  color_t           out_green;
  color_t           out_blue;
  logic             last_pixel;

  modport source (output valid, out_index, out_red, out_green, out_blue, last_pixel,
                  input ready);
  modport sink   (input valid, out_index, out_red, out_green, out_blue, last_pixel,
                  output ready);
endinterface

[sv/per_pixel_linear_fade.sv]
// Per-pixel linear fade. A set beat (operation 0) stores one pixel's start color and
// restarts its fade; an index at or above PIXELS is dropped. A tick beat (operation 1)
// walks pixels 0 to PIXELS-1: each pixel's step advances, saturating at FADE_STEPS,
// and one result beat per pixel carries each channel as color * (FADE_STEPS - step) /
// FADE_STEPS, last_pixel marking the final one. Each pixel goes through one memory
// read, one load and step write-back, two passes of the single shared multiplier per
// channel and one emit, which waits out any output stall. The input is not ready
// during a tick or in reset, so no new beat is taken until a tick is through.
// Per-pixel valid flags make every pixel read as black with step zero after reset,
// with no clearing pass.
module per_pixel_linear_fade
  import ppf_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  ppf_in_if.sink    in_ch,
  ppf_out_if.source out_ch
);

  state_t              state_r, state_nxt;
  pix_t                pix_r, pix_nxt;
  chan_t               ch_r, ch_nxt;
  logic [PIXELS-1:0]   valid_r, valid_nxt;
  logic                hit_r, hit_nxt;
  color_t              red_r, red_nxt;
  color_t              green_r, green_nxt;
  color_t              blue_r, blue_nxt;
  step_t               remain_r, remain_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  color_t              out_red_r, out_red_nxt;
  color_t              out_green_r, out_green_nxt;
  color_t              out_blue_r, out_blue_nxt;

  logic                ram_we;
  pix_t                ram_waddr;
  entry_t              ram_wdata;
  entry_t              ram_rdata;

  logic                in_fire, out_fire, idx_ok, last;
  entry_t              cur;
  step_t               step_old, step_new;
  color_t              color_sel;
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [2*MUL_W-1:0]  mul_p;

  ppf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pix_r),
    .rdata (ram_rdata)
  );

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign idx_ok   = in_ch.pixel_index < IDX_W'(PIXELS);
  assign last     = pix_r == PIX_AW'(PIXELS - 1);

  // Entry never written since reset reads as zero
  assign cur      = hit_r ? ram_rdata : '0;
  assign step_old = cur[STEP_W-1:0];
  assign step_new = (step_old < STEP_W'(FADE_STEPS)) ? step_old + 1'b1
                                                     : STEP_W'(FADE_STEPS);

  // Pick the channel fed to the shared multiplier
  always_comb begin
    case (ch_r)
      CH_RED:   color_sel = red_r;
      CH_GREEN: color_sel = green_r;
      CH_BLUE:  color_sel = blue_r;
      default:  color_sel = '0;
    endcase
  end

  // Shared multiplier: color * remain, then product * reciprocal
  always_comb begin
    if (state_r == S_MULA) begin
      mul_a = MUL_W'(color_sel);
      mul_b = MUL_W'(remain_r);
    end else begin
      mul_a = MUL_W'(prod_r);
      mul_b = MUL_W'(FADE_RECIP);
    end
  end
  assign mul_p = mul_a * mul_b;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_fire && in_ch.operation == OP_TICK) state_nxt = S_READ;
      S_READ: state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_MULA;
      S_MULA: state_nxt = S_MULB;
      S_MULB: state_nxt = (ch_r == CH_BLUE) ? S_EMIT : S_MULA;
      S_EMIT: if (out_fire) state_nxt = last ? S_IDLE : S_READ;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Handshakes and store writes
  always_comb begin
    in_ch.ready  = rst_n && (state_r == S_IDLE);
    out_ch.valid = state_r == S_EMIT;
    ram_we       = 1'b0;
    ram_waddr    = pix_r;
    ram_wdata    = {cur[ENTRY_W-1:STEP_W], step_new};
    case (state_r)
      S_IDLE: begin
        ram_we    = in_fire && in_ch.operation == OP_SET && idx_ok;
        ram_waddr = in_ch.pixel_index[PIX_AW-1:0];
        ram_wdata = {in_ch.set_red, in_ch.set_green, in_ch.set_blue, STEP_W'(0)};
      end
      S_LOAD:  ram_we = 1'b1;
      default: ram_we = 1'b0;
    endcase
  end

  // Datapath
  always_comb begin
    pix_nxt       = pix_r;
    ch_nxt        = ch_r;
    valid_nxt     = valid_r;
    hit_nxt       = hit_r;
    red_nxt       = red_r;
    green_nxt     = green_r;
    blue_nxt      = blue_r;
    remain_nxt    = remain_r;
    prod_nxt      = prod_r;
    out_red_nxt   = out_red_r;
    out_green_nxt = out_green_r;
    out_blue_nxt  = out_blue_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && in_ch.operation == OP_SET && idx_ok) begin
          valid_nxt[in_ch.pixel_index[PIX_AW-1:0]] = 1'b1;
        end
        if (in_fire && in_ch.operation == OP_TICK) begin
          pix_nxt = '0;
        end
      end
      S_READ: hit_nxt = valid_r[pix_r];
      S_LOAD: begin
        red_nxt        = cur[STEP_W+3*COLOR_W-1:STEP_W+2*COLOR_W];
        green_nxt      = cur[STEP_W+2*COLOR_W-1:STEP_W+COLOR_W];
        blue_nxt       = cur[STEP_W+COLOR_W-1:STEP_W];
        remain_nxt     = STEP_W'(FADE_STEPS) - step_new;
        valid_nxt[pix_r] = 1'b1;
        ch_nxt         = CH_RED;
      end
      S_MULA: prod_nxt = mul_p[PROD_W-1:0];
      S_MULB: begin
        case (ch_r)
          CH_RED: begin
            out_red_nxt = mul_p[FADE_SHIFT+COLOR_W-1:FADE_SHIFT];
            ch_nxt      = CH_GREEN;
          end
          CH_GREEN: begin
            out_green_nxt = mul_p[FADE_SHIFT+COLOR_W-1:FADE_SHIFT];
            ch_nxt        = CH_BLUE;
          end
          default: out_blue_nxt = mul_p[FADE_SHIFT+COLOR_W-1:FADE_SHIFT];
        endcase
      end
      S_EMIT: if (out_fire && !last) pix_nxt = pix_r + 1'b1;
      default: pix_nxt = pix_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pix_r   <= '0;
      ch_r    <= CH_RED;
      valid_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pix_r   <= pix_nxt;
      ch_r    <= ch_nxt;
      valid_r <= valid_nxt;
      hit_r   <= hit_nxt;
    end
    red_r       <= red_nxt;
    green_r     <= green_nxt;
    blue_r      <= blue_nxt;
    remain_r    <= remain_nxt;
    prod_r      <= prod_nxt;
    out_red_r   <= out_red_nxt;
    out_green_r <= out_green_nxt;
    out_blue_r  <= out_blue_nxt;
  end

  // Drive the result beat
  assign out_ch.out_index  = IDX_W'(pix_r);
  assign out_ch.out_red    = out_red_r;
  assign out_ch.out_green  = out_green_r;
  assign out_ch.out_blue   = out_blue_r;
  assign out_ch.last_pixel = last;

  // A tick starts its walk at pixel zero
  a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.operation == OP_TICK |=> state_r == S_READ && pix_r == '0)
    else $error("tick did not start at pixel zero");

  // The final beat of a tick returns the block to idle
  a_tick_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_ch.last_pixel |=> state_r == S_IDLE)
    else $error("block not idle after last pixel");

  // A loaded pixel is marked written
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOAD |=> valid_r[$past(pix_r)])
    else $error("loaded pixel not marked valid");

  // The remaining fade never exceeds the fade length
  a_remain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MULA |-> remain_r < STEP_W'(FADE_STEPS))
    else $error("remaining fade out of range");

  // Results only follow the blue channel pass
  a_emit_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(state_r) == S_MULB && $past(ch_r) == CH_BLUE)
    else $error("result shown before all channels done");

endmodule

[sv/ppf_ram.sv]
module ppf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
